FILE: rtl/core/iesc_pkg.sv
// Shared types and character codes for the infix expression syntax checker.
// No dependencies; every other file of the block imports this package.
package iesc_pkg;

   // Character codes of the expression alphabet.
   localparam logic [7:0] CHAR_END     = 8'h00;
   localparam logic [7:0] CHAR_FN_COS  = 8'(int'("A") + 1);
   localparam logic [7:0] CHAR_FN_COSH = 8'(int'("A") + 2);
   localparam logic [7:0] CHAR_OP_DIV  = 8'(int'("A") + 3);
   localparam logic [7:0] CHAR_LG      = 8'(int'("A") + 4);
   localparam logic [7:0] CHAR_LN      = 8'(int'("A") + 5);
   localparam logic [7:0] CHAR_OP_MUL  = 8'(int'("A") + 6);
   localparam logic [7:0] CHAR_PI      = 8'(int'("A") + 7);
   localparam logic [7:0] CHAR_FN_SIN  = 8'(int'("A") + 8);
   localparam logic [7:0] CHAR_FN_SINH = 8'(int'("A") + 9);
   localparam logic [7:0] CHAR_FN_SQRT = 8'(int'("A") + 10);
   localparam logic [7:0] CHAR_CBRT    = 8'(int'("A") + 11);
   localparam logic [7:0] CHAR_FN_TAN  = 8'(int'("A") + 12);
   localparam logic [7:0] CHAR_FN_TANH = 8'(int'("A") + 13);
   localparam logic [7:0] CHAR_SQR     = 8'(int'("A") + 14);
   localparam logic [7:0] CHAR_CUBE    = 8'(int'("A") + 15);
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_POINT   = 8'h2E;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_MINUS   = 8'h2D;
   localparam logic [7:0] CHAR_POW     = 8'h5E;
   localparam logic [7:0] CHAR_E       = 8'h65;
   localparam logic [7:0] CHAR_OPEN    = 8'h28;
   localparam logic [7:0] CHAR_CLOSE   = 8'h29;

   // Token kinds produced by the classifier.
   typedef enum logic [3:0] {
      TOK_IGNORE,
      TOK_END,
      TOK_DIGIT,
      TOK_POINT,
      TOK_CONST,
      TOK_BINOP,
      TOK_MINUS,
      TOK_FUNC,
      TOK_POSTFIX,
      TOK_OPEN,
      TOK_CLOSE
   } token_type;

   // Syntactic class of the most recent character.
   typedef enum logic [2:0] {
      CLS_NUMBER  = 3'd1,
      CLS_BINOP   = 3'd2,
      CLS_PREFIX  = 3'd3,
      CLS_POSTFIX = 3'd4,
      CLS_OPEN    = 3'd5,
      CLS_CLOSE   = 3'd6,
      CLS_CONST   = 3'd7
   } class_type;

   // Fill levels of the two-entry token queue.
   localparam logic [1:0] QUEUE_EMPTY = 2'd0;
   localparam logic [1:0] QUEUE_ONE   = 2'd1;
   localparam logic [1:0] QUEUE_FULL  = 2'd2;

endpackage

FILE: rtl/core/iesc_front.sv
// Front end: accepts characters and registers their token kind.
// Depends on iesc_pkg.
module iesc_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // [7:0] char_code
   output logic              tok_valid,
   input  logic              tok_ready,
   output iesc_pkg::token_type tok_kind
);
   import iesc_pkg::*;

   logic      tok_valid_ff;
   token_type tok_ff;
   token_type tok_in;

   assign req_tready = !tok_valid_ff || tok_ready;
   assign tok_valid  = tok_valid_ff;
   assign tok_kind   = tok_ff;

   always_comb begin
      unique case (req_tdata) inside
         CHAR_END:                                       tok_in = TOK_END;
         [CHAR_ZERO:CHAR_NINE]:                          tok_in = TOK_DIGIT;
         CHAR_POINT:                                     tok_in = TOK_POINT;
         CHAR_E, CHAR_PI:                                tok_in = TOK_CONST;
         CHAR_PLUS, CHAR_OP_MUL, CHAR_OP_DIV, CHAR_POW:  tok_in = TOK_BINOP;
         CHAR_MINUS:                                     tok_in = TOK_MINUS;
         CHAR_FN_SIN, CHAR_FN_COS, CHAR_FN_TAN, CHAR_FN_SINH, CHAR_FN_COSH, CHAR_FN_TANH,
         CHAR_LN, CHAR_LG, CHAR_FN_SQRT, CHAR_CBRT:      tok_in = TOK_FUNC;
         CHAR_SQR, CHAR_CUBE:                            tok_in = TOK_POSTFIX;
         CHAR_OPEN:                                      tok_in = TOK_OPEN;
         CHAR_CLOSE:                                     tok_in = TOK_CLOSE;
         default:                                        tok_in = TOK_IGNORE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else if (req_tready) begin
         tok_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         tok_ff <= tok_in;
      end
   end

endmodule

FILE: rtl/core/iesc_queue.sv
// Two-entry token queue between the classifier and the checker.
// Depends on iesc_pkg. Entry zero is always the head.
module iesc_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  iesc_pkg::token_type push_kind,
   output logic              pop_valid,
   input  logic              pop_ready,
   output iesc_pkg::token_type pop_kind
);
   import iesc_pkg::*;

   logic [1:0] count_ff;
   logic [1:0] count_in;
   token_type  head_ff;
   token_type  head_in;
   token_type  tail_ff;
   token_type  tail_in;
   logic       push;
   logic       pop;

   assign push_ready = (count_ff != QUEUE_FULL);
   assign pop_valid  = (count_ff != QUEUE_EMPTY);
   assign pop_kind   = head_ff;
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      count_in = count_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      if (pop) begin
         head_in = tail_ff;
      end
      if (push) begin
         // The new entry lands behind whatever remains after the pop.
         if ((count_ff == QUEUE_EMPTY) || (pop && (count_ff == QUEUE_ONE))) begin
            head_in = push_kind;
         end else begin
            tail_in = push_kind;
         end
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= QUEUE_EMPTY;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

endmodule

FILE: rtl/core/iesc_back.sv
// Back end: applies the class transition rules, tracks decimal points and
// bracket depth, latches the first error and holds the result register.
// Depends on iesc_pkg.
module iesc_back #(
   parameter int unsigned MAX_NESTING = 255
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              tok_valid,
   output logic              tok_ready,
   input  iesc_pkg::token_type tok_kind,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output logic              rsp_tlast,
   output logic              rsp_error
);
   import iesc_pkg::*;

   localparam int DepthWidth = $clog2(MAX_NESTING + 1);
   localparam logic [DepthWidth-1:0] DepthMax = DepthWidth'(MAX_NESTING);

   class_type             prev_ff;
   class_type             prev_in;
   logic                  point_ff;
   logic                  point_in;
   logic [DepthWidth-1:0] depth_ff;
   logic [DepthWidth-1:0] depth_in;
   logic                  error_ff;
   logic                  error_in;
   logic                  valid_ff;
   logic                  last_ff;
   logic                  last_in;
   logic                  verdict_ff;
   logic                  verdict_in;
   logic                  take;
   logic                  after_operand;
   logic                  wants_operand;
   logic                  bad;

   assign tok_ready  = !valid_ff || rsp_tready;
   assign take       = tok_valid && tok_ready;
   assign rsp_tvalid = valid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_error  = verdict_ff;

   always_comb begin
      case (prev_ff) inside
         CLS_NUMBER, CLS_POSTFIX, CLS_CLOSE, CLS_CONST: after_operand = 1'b1;
         default:                                       after_operand = 1'b0;
      endcase
      case (prev_ff) inside
         CLS_BINOP, CLS_PREFIX, CLS_OPEN: wants_operand = 1'b1;
         default:                         wants_operand = 1'b0;
      endcase
   end

   always_comb begin
      prev_in    = prev_ff;
      point_in   = point_ff;
      depth_in   = depth_ff;
      bad        = 1'b0;
      last_in    = 1'b0;
      if (tok_kind == TOK_END) begin
         last_in  = 1'b1;
         prev_in  = CLS_OPEN;
         point_in = 1'b0;
         depth_in = '0;
         error_in = 1'b0;
         verdict_in = error_ff || wants_operand;
      end else begin
         if (!error_ff) begin
            unique case (tok_kind)
               TOK_DIGIT, TOK_POINT: begin
                  if (prev_ff != CLS_NUMBER) begin
                     bad      = after_operand;
                     point_in = 1'b0;
                     prev_in  = CLS_NUMBER;
                  end
                  if (tok_kind == TOK_POINT) begin
                     // A second point counts only within the same number.
                     if ((prev_ff == CLS_NUMBER) && point_ff) begin
                        bad = 1'b1;
                     end
                     point_in = 1'b1;
                  end
               end
               TOK_CONST: begin
                  bad     = after_operand;
                  prev_in = CLS_CONST;
               end
               TOK_BINOP: begin
                  bad     = wants_operand;
                  prev_in = CLS_BINOP;
               end
               TOK_MINUS: begin
                  prev_in = wants_operand ? CLS_PREFIX : CLS_BINOP;
               end
               TOK_FUNC: begin
                  bad     = after_operand;
                  prev_in = CLS_PREFIX;
               end
               TOK_POSTFIX: begin
                  bad     = wants_operand;
                  prev_in = CLS_POSTFIX;
               end
               TOK_OPEN: begin
                  prev_in = CLS_OPEN;
                  if (depth_ff == DepthMax) begin
                     bad = 1'b1;
                  end else begin
                     bad      = after_operand;
                     depth_in = depth_ff + DepthWidth'(1);
                  end
               end
               TOK_CLOSE: begin
                  prev_in = CLS_CLOSE;
                  if (depth_ff == '0) begin
                     bad = 1'b1;
                  end else begin
                     bad      = wants_operand;
                     depth_in = depth_ff - DepthWidth'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         error_in   = error_ff || bad;
         verdict_in = error_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= CLS_OPEN;
         point_ff <= 1'b0;
         depth_ff <= '0;
         error_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         if (take) begin
            prev_ff  <= prev_in;
            point_ff <= point_in;
            depth_ff <= depth_in;
            error_ff <= error_in;
         end
         if (tok_ready) begin
            valid_ff <= tok_valid;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         last_ff    <= last_in;
         verdict_ff <= verdict_in;
      end
   end

endmodule

FILE: rtl/core/infix_expression_syntax_checker_unit.sv
// Infix expression syntax checker. Takes one expression character per cycle
// and returns one result per character; a zero byte ends the expression and
// its result carries tlast with the final verdict, after which all checker
// state returns to its start values. Each character passes the classifier
// register and a two-entry token queue before it reaches the result
// register. The checker updates its class, point and bracket state once
// per token and takes one character per cycle while rsp_tready is high;
// a low rsp_tready stalls it. Brackets nested deeper than MAX_NESTING
// are an error; brackets left open at the end are accepted.
module infix_expression_syntax_checker_unit #(
   parameter int unsigned MAX_NESTING = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [0] syntax_error, [7:1] zero
   output logic       rsp_tlast    // expression_end
);
   import iesc_pkg::*;

   logic      front_valid;
   logic      front_ready;
   token_type front_kind;
   logic      queue_valid;
   logic      queue_ready;
   token_type queue_kind;
   logic      rsp_error;

   iesc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .tok_valid  (front_valid),
      .tok_ready  (front_ready),
      .tok_kind   (front_kind)
   );

   iesc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_kind  (front_kind),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_kind   (queue_kind)
   );

   iesc_back #(
      .MAX_NESTING (MAX_NESTING)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .tok_valid  (queue_valid),
      .tok_ready  (queue_ready),
      .tok_kind   (queue_kind),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tlast  (rsp_tlast),
      .rsp_error  (rsp_error)
   );

   assign rsp_tdata = {7'b0, rsp_error};

endmodule
